// File: src/bfcma_pkg.sv
package bfcma_pkg;

   localparam int MAX_RESULTS = 16;

   localparam logic [1:0] FUNC_ZERO   = 2'd0;
   localparam logic [1:0] FUNC_ACC    = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
   localparam logic [15:0] QNAN16 = 16'h7FC0;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  group;
      logic [3:0]  column;
      logic [15:0] a_value;
      logic [15:0] w_value;
   } req_type;

   typedef struct packed {
      logic [15:0] out_value;
      logic [2:0]  out_group;
      logic [3:0]  out_column;
      logic        last;
   } rsp_type;

   function automatic logic [15:0] to_bf16(input logic [31:0] f);
      logic [31:0] sum;
      sum = f + 32'h0000_7FFF + {31'b0, f[16]};
      if (f[30:23] == 8'hFF && f[22:0] != 23'b0) begin
         return QNAN16;
      end
      return sum[31:16];
   endfunction

endpackage

// File: src/bf16_column_mac_accumulator.sv
// Zero item: one accumulator written per cycle, clearing every column of the group.
// Accumulate item: special operands go straight to done; else the fp32 adder runs its
// serial steps in order (normalize, align, add, renormalize, round).
// Finish item: each result is read, loaded and sent, waiting on output stall; one item at a time.
// Reset is synchronous and clears control state; the accumulator memory is not
// cleared and holds undefined data until a zero item writes a group.
module bf16_column_mac_accumulator import bfcma_pkg::*; #(
   parameter int LANES  = 16,
   parameter int GROUPS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int DEPTH = GROUPS * LANES;
   localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int LW = LANES > 1 ? $clog2(LANES) : 1;
   localparam int NRES = LANES < MAX_RESULTS ? LANES : MAX_RESULTS;

   typedef enum logic [2:0] {
      S_IDLE, S_ZERO, S_ACC_READ, S_ACC_START, S_ACC_WAIT,
      S_FIN_READ, S_FIN_LOAD, S_FIN_SEND
   } state_type;

   state_type      state_ff;
   req_type        req_ff;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff;
   logic [LW-1:0]  col_ff;

   logic [AW-1:0]  acc_addr, col_addr;
   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [31:0]    ram_wdata, ram_rdata;
   logic           mac_start, mac_done;
   logic [31:0]    mac_result;
   logic           group_ok, column_ok, col_end, fin_end;

   assign acc_addr = AW'(int'(req_ff.group) * LANES + int'(req_ff.column));
   assign col_addr = AW'(int'(req_ff.group) * LANES + int'(col_ff));
   assign group_ok = int'(req_item.group) < GROUPS;
   assign column_ok = int'(req_item.column) < LANES;
   assign col_end = col_ff == LW'(LANES - 1);
   assign fin_end = col_ff == LW'(NRES - 1);

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = col_addr;
      ram_wdata = 32'b0;
      ram_re = 1'b0;
      ram_raddr = col_addr;
      mac_start = 1'b0;
      case (state_ff)
         S_ZERO: begin
            ram_we = 1'b1;
         end
         S_ACC_READ: begin
            ram_re = 1'b1;
            ram_raddr = acc_addr;
         end
         S_ACC_START: begin
            mac_start = 1'b1;
         end
         S_ACC_WAIT: begin
            ram_we = mac_done;
            ram_waddr = acc_addr;
            ram_wdata = mac_result;
         end
         S_FIN_READ: begin
            ram_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   bfcma_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bfcma_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .acc     (ram_rdata),
      .a_value (req_ff.a_value),
      .w_value (req_ff.w_value),
      .done    (mac_done),
      .result  (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_item;
                  col_ff <= '0;
                  if (group_ok) begin
                     case (req_item.func)
                        FUNC_ZERO:   state_ff <= S_ZERO;
                        FUNC_ACC:    state_ff <= column_ok ? S_ACC_READ : S_IDLE;
                        FUNC_FINISH: state_ff <= S_FIN_READ;
                        default:     state_ff <= S_IDLE;
                     endcase
                  end
               end
            end
            S_ZERO: begin
               if (col_end) begin
                  state_ff <= S_IDLE;
               end else begin
                  col_ff <= col_ff + LW'(1);
               end
            end
            S_ACC_READ: begin
               state_ff <= S_ACC_START;
            end
            S_ACC_START: begin
               state_ff <= S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
               if (mac_done) begin
                  state_ff <= S_IDLE;
               end
            end
            S_FIN_READ: begin
               state_ff <= S_FIN_LOAD;
            end
            S_FIN_LOAD: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.out_value <= to_bf16(ram_rdata);
               rsp_ff.out_group <= req_ff.group;
               rsp_ff.out_column <= 4'(col_ff);
               rsp_ff.last <= fin_end;
               state_ff <= S_FIN_SEND;
            end
            S_FIN_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_ff.last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     col_ff <= col_ff + LW'(1);
                     state_ff <= S_FIN_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

// File: src/bfcma_ram.sv
module bfcma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bfcma_mac.sv
module bfcma_mac import bfcma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] acc,
   input  logic [15:0] a_value,
   input  logic [15:0] w_value,
   output logic        done,
   output logic [31:0] result
);

   typedef enum logic [2:0] {
      M_IDLE, M_NORM, M_ALIGN, M_ADD, M_FIX, M_ROUND, M_DONE
   } mstate_type;

   localparam logic signed [11:0] EMIN = -12'sd152;

   mstate_type        state_ff;
   logic [23:0]       pm_ff, cm_ff;
   logic signed [11:0] pe_ff, ce_ff, ef_ff;
   logic              cz_ff, sp_ff, sc_ff, sb_ff, sub_ff;
   logic [27:0]       big_ff, small_ff;
   logic [4:0]        cnt_ff;
   logic [31:0]       res_ff;

   logic        sa, sw, sc, sp;
   logic [7:0]  ea, ew, ec;
   logic [6:0]  ma, mw;
   logic [22:0] mc;
   logic        nan_any, inf_a, inf_w, inf_c, zero_a, zero_w, p_zero, c_zero;
   logic [7:0]  ma_full, mw_full;
   logic [15:0] prod;
   logic [23:0] c_full;
   logic signed [11:0] pe_c, ce_c;
   logic        special;
   logic [31:0] special_val;

   always_comb begin
      sa = a_value[15];
      ea = a_value[14:7];
      ma = a_value[6:0];
      sw = w_value[15];
      ew = w_value[14:7];
      mw = w_value[6:0];
      sc = acc[31];
      ec = acc[30:23];
      mc = acc[22:0];
      sp = sa ^ sw;
      inf_a = ea == 8'hFF && ma == 7'b0;
      inf_w = ew == 8'hFF && mw == 7'b0;
      inf_c = ec == 8'hFF && mc == 23'b0;
      zero_a = ea == 8'h00 && ma == 7'b0;
      zero_w = ew == 8'h00 && mw == 7'b0;
      nan_any = (ea == 8'hFF && ma != 7'b0) || (ew == 8'hFF && mw != 7'b0)
         || (ec == 8'hFF && mc != 23'b0);
      ma_full = {ea != 8'h00, ma};
      mw_full = {ew != 8'h00, mw};
      prod = ma_full * mw_full;
      pe_c = $signed({4'b0, (ea != 8'h00) ? ea : 8'd1})
         + $signed({4'b0, (ew != 8'h00) ? ew : 8'd1}) - 12'sd268;
      c_full = {ec != 8'h00, mc};
      ce_c = $signed({4'b0, (ec != 8'h00) ? ec : 8'd1}) - 12'sd150;
      p_zero = prod == 16'b0;
      c_zero = c_full == 24'b0;
      special = 1'b1;
      special_val = acc;
      if (nan_any) begin
         special_val = QNAN32;
      end else if (inf_a || inf_w) begin
         if ((inf_a && zero_w) || (inf_w && zero_a) || (inf_c && sc != sp)) begin
            special_val = QNAN32;
         end else begin
            special_val = {sp, 8'hFF, 23'b0};
         end
      end else if (inf_c) begin
         special_val = acc;
      end else if (p_zero && c_zero) begin
         special_val = {sc & sp, 31'b0};
      end else if (p_zero) begin
         special_val = acc;
      end else begin
         special = 1'b0;
      end
   end

   logic        pm_norm, cm_norm, p_big;
   logic [23:0] bm, sm;
   logic signed [11:0] eb, es, diff;

   always_comb begin
      pm_norm = pm_ff[23];
      cm_norm = cz_ff | cm_ff[23];
      p_big = cz_ff || (pe_ff > ce_ff) || (pe_ff == ce_ff && pm_ff >= cm_ff);
      bm = p_big ? pm_ff : cm_ff;
      sm = p_big ? cm_ff : pm_ff;
      eb = p_big ? pe_ff : ce_ff;
      es = p_big ? ce_ff : pe_ff;
      diff = eb - es;
   end

   logic [27:0] sum;
   logic        up;
   logic [24:0] q;
   logic [23:0] qn;
   logic signed [11:0] efn, be;
   logic [31:0] round_val;

   always_comb begin
      sum = sub_ff ? big_ff - small_ff : big_ff + small_ff;
      up = big_ff[2] & (big_ff[1] | big_ff[0] | big_ff[3]);
      q = {1'b0, big_ff[26:3]} + {24'b0, up};
      qn = q[24] ? q[24:1] : q[23:0];
      efn = ef_ff + (q[24] ? 12'sd1 : 12'sd0);
      be = efn + 12'sd153;
      if (qn[23]) begin
         if (be >= 12'sd255) begin
            round_val = {sb_ff, 8'hFF, 23'b0};
         end else begin
            round_val = {sb_ff, be[7:0], qn[22:0]};
         end
      end else begin
         round_val = {sb_ff, 8'h00, qn[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  res_ff <= special_val;
                  pm_ff <= {prod, 8'b0};
                  pe_ff <= pe_c - 12'sd8;
                  cm_ff <= c_full;
                  ce_ff <= ce_c;
                  cz_ff <= c_zero;
                  sp_ff <= sp;
                  sc_ff <= sc;
                  state_ff <= special ? M_DONE : M_NORM;
               end
            end
            M_NORM: begin
               if (!pm_norm) begin
                  pm_ff <= {pm_ff[22:0], 1'b0};
                  pe_ff <= pe_ff - 12'sd1;
               end
               if (!cm_norm) begin
                  cm_ff <= {cm_ff[22:0], 1'b0};
                  ce_ff <= ce_ff - 12'sd1;
               end
               if (pm_norm && cm_norm) begin
                  big_ff <= {1'b0, bm, 3'b0};
                  small_ff <= cz_ff ? 28'b0 : {1'b0, sm, 3'b0};
                  ef_ff <= eb - 12'sd3;
                  sb_ff <= p_big ? sp_ff : sc_ff;
                  sub_ff <= sp_ff ^ sc_ff;
                  if (cz_ff) begin
                     cnt_ff <= 5'd0;
                  end else if (diff > 12'sd28) begin
                     cnt_ff <= 5'd28;
                  end else begin
                     cnt_ff <= diff[4:0];
                  end
                  state_ff <= M_ALIGN;
               end
            end
            M_ALIGN: begin
               if (cnt_ff != 5'd0) begin
                  small_ff <= {1'b0, small_ff[27:2], small_ff[1] | small_ff[0]};
                  cnt_ff <= cnt_ff - 5'd1;
               end else begin
                  state_ff <= M_ADD;
               end
            end
            M_ADD: begin
               if (sum == 28'b0) begin
                  res_ff <= 32'b0;
                  state_ff <= M_DONE;
               end else begin
                  big_ff <= sum;
                  state_ff <= M_FIX;
               end
            end
            M_FIX: begin
               if (big_ff[27]) begin
                  big_ff <= {1'b0, big_ff[27:2], big_ff[1] | big_ff[0]};
                  ef_ff <= ef_ff + 12'sd1;
               end else if (ef_ff < EMIN) begin
                  if (big_ff[27:1] == 27'b0) begin
                     ef_ff <= EMIN;
                  end else begin
                     big_ff <= {1'b0, big_ff[27:2], big_ff[1] | big_ff[0]};
                     ef_ff <= ef_ff + 12'sd1;
                  end
               end else if (!big_ff[26] && ef_ff > EMIN) begin
                  big_ff <= {big_ff[26:0], 1'b0};
                  ef_ff <= ef_ff - 12'sd1;
               end else begin
                  state_ff <= M_ROUND;
               end
            end
            M_ROUND: begin
               res_ff <= round_val;
               state_ff <= M_DONE;
            end
            M_DONE: begin
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign done = state_ff == M_DONE;
   assign result = res_ff;

endmodule
